FILE: src/dsdt_pkg.sv
`default_nettype none

package dsdt_pkg;

    // cylinder field width and derived sizes
    localparam int CYL_BITS   = 12;
    localparam int IN_DATA_W  = ((CYL_BITS + 7) / 8) * 8;
    localparam int TOTAL_W    = 24;
    localparam int OUT_DATA_W = ((TOTAL_W + 7) / 8) * 8;
    localparam int CALC_W     = TOTAL_W + 1;
    localparam int MODE_W     = 2;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [TOTAL_W-1:0]  TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [CALC_W-1:0]   CALC_MAX  = {1'b0, {TOTAL_W{1'b1}}};
    localparam logic [CYL_BITS-1:0] TOP_RESET = CYL_BITS'(199);
    localparam logic [CYL_BITS-1:0] CYL_ONES  = {CYL_BITS{1'b1}};

    // scheduling modes
    localparam logic [MODE_W-1:0] MODE_FCFS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

    // register indexes (word address bits)
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_START = 2'd1;
    localparam logic [1:0] REG_TOP   = 2'd2;

    // one request after classification against the start position
    typedef struct packed {
        logic [CYL_BITS-1:0] cyl;
        logic                last;
        logic                below;
    } item_t;

    // batch summary handed to the finishing stage
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [CYL_BITS-1:0] batch_start;
        logic [CYL_BITS-1:0] top;
        logic [CYL_BITS-1:0] highest_above;
        logic                any_above;
        logic [CYL_BITS-1:0] highest_below;
        logic [CYL_BITS-1:0] lowest_below;
        logic                any_below;
        logic [TOTAL_W-1:0]  running_total;
        logic                overflow;
    } snap_t;

    function automatic logic [CYL_BITS-1:0] cyl_dist(
        input logic [CYL_BITS-1:0] a,
        input logic [CYL_BITS-1:0] b
    );
        logic [CYL_BITS-1:0] d;
        if (a > b)
        begin
            d = a - b;
        end
        else
        begin
            d = b - a;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: src/disk_seek_distance_total.sv
// Disk seek distance totaler: FCFS, SCAN and C-SCAN head movement.
// Input stream: one beat per cylinder request, tdata[11:0] the cylinder,
// tlast closing the batch. Output stream: one beat per batch, tdata[23:0]
// the total movement (saturating), tuser set when the total was clipped.
// The APB port holds mode (0x0), start_head (0x4) and top_cylinder (0x8);
// write them only while no accepted request is still queued. A start_head
// write inside an open batch applies from the next batch on.
// Throughput: one request per cycle until a stalled receiver has filled the queue;
// the back end folds each request into a running sum and min/max registers.
// A closing beat's result passes through the queue entry, the batch summary
// register and the output register before it is offered.
// A two-entry queue sits between request intake and the batch update, so
// a stalled receiver first fills the summary and output registers, then
// the queue, and only then drops s_axis_tready.
// Reset clears the queue, the batch state and the output, and loads mode 0,
// start_head 0 and top_cylinder 199.
`default_nettype none

module disk_seek_distance_total (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input requests
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [dsdt_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [11:0] cylinder, rest zero
    input  wire logic                              s_axis_tlast,
    // batch results
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [dsdt_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // [23:0] total_movement
    output logic                                   m_axis_tuser,  // [0] saturated
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dsdt_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [dsdt_pkg::DATA_W-1:0]       pwdata,
    output logic [dsdt_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready
);

    logic [dsdt_pkg::MODE_W-1:0]   mode_reg;
    logic [dsdt_pkg::CYL_BITS-1:0] start_head_reg;
    logic [dsdt_pkg::CYL_BITS-1:0] top_reg;
    logic                          cfg_wr;
    logic [1:0]                    reg_idx;

    logic                          q_valid;
    dsdt_pkg::item_t               q_item;
    logic                          pop;
    logic                          snap_valid;
    dsdt_pkg::snap_t               snap;
    logic                          fin_ready;
    logic [dsdt_pkg::TOTAL_W-1:0]  out_total;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= dsdt_pkg::MODE_FCFS;
            start_head_reg <= '0;
            top_reg        <= dsdt_pkg::TOP_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                dsdt_pkg::REG_MODE:  mode_reg       <= pwdata[dsdt_pkg::MODE_W-1:0];
                dsdt_pkg::REG_START: start_head_reg <= pwdata[dsdt_pkg::CYL_BITS-1:0];
                dsdt_pkg::REG_TOP:   top_reg        <= pwdata[dsdt_pkg::CYL_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_idx)
            dsdt_pkg::REG_MODE:  prdata = dsdt_pkg::DATA_W'(mode_reg);
            dsdt_pkg::REG_START: prdata = dsdt_pkg::DATA_W'(start_head_reg);
            dsdt_pkg::REG_TOP:   prdata = dsdt_pkg::DATA_W'(top_reg);
            default:             prdata = '0;
        endcase
    end

    dsdt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cyl     (s_axis_tdata[dsdt_pkg::CYL_BITS-1:0]),
        .in_last    (s_axis_tlast),
        .start_head (start_head_reg),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_item     (q_item)
    );

    dsdt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop),
        .mode         (mode_reg),
        .start_head   (start_head_reg),
        .top_cylinder (top_reg),
        .fin_ready    (fin_ready),
        .snap_valid   (snap_valid),
        .snap         (snap)
    );

    dsdt_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .fin_ready  (fin_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_total  (out_total),
        .out_sat    (m_axis_tuser)
    );

    assign m_axis_tdata = dsdt_pkg::OUT_DATA_W'(out_total);

endmodule

`default_nettype wire

FILE: src/dsdt_front.sv
`default_nettype none

module dsdt_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dsdt_pkg::CYL_BITS-1:0] in_cyl,
    input  wire logic                          in_last,
    input  wire logic [dsdt_pkg::CYL_BITS-1:0] start_head,
    input  wire logic                          pop,
    output logic                               q_valid,
    output dsdt_pkg::item_t                    q_item
);

    dsdt_pkg::item_t               mem_reg [2];
    logic                          wr_ptr_reg, wr_ptr_next;
    logic                          rd_ptr_reg, rd_ptr_next;
    logic [1:0]                    count_reg, count_next;
    logic                          batch_open_reg, batch_open_next;
    logic [dsdt_pkg::CYL_BITS-1:0] batch_start_reg, batch_start_next;
    logic [dsdt_pkg::CYL_BITS-1:0] split_at;
    logic                          push;
    dsdt_pkg::item_t               new_item;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    // start position of the open batch, taken from the register on its first beat
    assign split_at = batch_open_reg ? batch_start_reg : start_head;

    // classify against the start position, stable for the whole batch
    always_comb
    begin
        new_item.cyl   = in_cyl;
        new_item.last  = in_last;
        new_item.below = (in_cyl <= split_at);
    end

    // batch tracking on the intake side
    always_comb
    begin
        batch_open_next  = batch_open_reg;
        batch_start_next = batch_start_reg;
        if (push)
        begin
            batch_open_next  = !in_last;
            batch_start_next = split_at;
        end
    end

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg      <= 1'b0;
            rd_ptr_reg      <= 1'b0;
            count_reg       <= 2'd0;
            batch_open_reg  <= 1'b0;
            batch_start_reg <= '0;
        end
        else
        begin
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
            batch_open_reg  <= batch_open_next;
            batch_start_reg <= batch_start_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

FILE: src/dsdt_back.sv
`default_nettype none

module dsdt_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire dsdt_pkg::item_t               q_item,
    output logic                               pop,
    input  wire logic [dsdt_pkg::MODE_W-1:0]   mode,
    input  wire logic [dsdt_pkg::CYL_BITS-1:0] start_head,
    input  wire logic [dsdt_pkg::CYL_BITS-1:0] top_cylinder,
    input  wire logic                          fin_ready,
    output logic                               snap_valid,
    output dsdt_pkg::snap_t                    snap
);

    logic                          in_batch_reg, in_batch_next;
    logic [dsdt_pkg::CYL_BITS-1:0] head_now_reg, head_now_next;
    logic [dsdt_pkg::CYL_BITS-1:0] batch_start_reg, batch_start_next;
    logic [dsdt_pkg::TOTAL_W-1:0]  running_total_reg, running_total_next;
    logic                          overflow_reg, overflow_next;
    logic [dsdt_pkg::CYL_BITS-1:0] lowest_below_reg, lowest_below_next;
    logic [dsdt_pkg::CYL_BITS-1:0] highest_below_reg, highest_below_next;
    logic                          any_below_reg, any_below_next;
    logic [dsdt_pkg::CYL_BITS-1:0] highest_above_reg, highest_above_next;
    logic                          any_above_reg, any_above_next;
    logic                          snap_valid_reg, snap_valid_next;
    dsdt_pkg::snap_t               snap_reg, snap_next;

    logic [dsdt_pkg::CYL_BITS-1:0] head;
    logic [dsdt_pkg::CYL_BITS-1:0] bstart;
    logic [dsdt_pkg::CALC_W-1:0]   sum;
    logic [dsdt_pkg::TOTAL_W-1:0]  tot_upd;
    logic                          ovf_upd;
    logic [dsdt_pkg::CYL_BITS-1:0] lb_upd, hb_upd, ha_upd;
    logic                          ab_upd, aa_upd;

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    // take a request whenever the summary slot is free or draining
    assign pop = q_valid && (!snap_valid_reg || fin_ready);

    // running sum and min/max update for the request at the queue head
    always_comb
    begin
        head   = in_batch_reg ? head_now_reg : start_head;
        bstart = in_batch_reg ? batch_start_reg : start_head;
        sum    = {1'b0, running_total_reg}
               + dsdt_pkg::CALC_W'(dsdt_pkg::cyl_dist(head, q_item.cyl));
        if (sum > dsdt_pkg::CALC_MAX)
        begin
            tot_upd = dsdt_pkg::TOTAL_MAX;
            ovf_upd = 1'b1;
        end
        else
        begin
            tot_upd = sum[dsdt_pkg::TOTAL_W-1:0];
            ovf_upd = overflow_reg;
        end

        lb_upd = lowest_below_reg;
        hb_upd = highest_below_reg;
        ab_upd = any_below_reg;
        ha_upd = highest_above_reg;
        aa_upd = any_above_reg;
        if (q_item.below)
        begin
            if (q_item.cyl < lowest_below_reg)
            begin
                lb_upd = q_item.cyl;
            end
            if (q_item.cyl > highest_below_reg)
            begin
                hb_upd = q_item.cyl;
            end
            ab_upd = 1'b1;
        end
        else
        begin
            if (q_item.cyl > highest_above_reg)
            begin
                ha_upd = q_item.cyl;
            end
            aa_upd = 1'b1;
        end
    end

    // batch state and summary slot
    always_comb
    begin
        in_batch_next      = in_batch_reg;
        head_now_next      = head_now_reg;
        batch_start_next   = batch_start_reg;
        running_total_next = running_total_reg;
        overflow_next      = overflow_reg;
        lowest_below_next  = lowest_below_reg;
        highest_below_next = highest_below_reg;
        any_below_next     = any_below_reg;
        highest_above_next = highest_above_reg;
        any_above_next     = any_above_reg;
        snap_valid_next    = snap_valid_reg && !fin_ready;
        snap_next          = snap_reg;

        if (pop)
        begin
            if (q_item.last)
            begin
                // close the batch and hand off its summary
                snap_valid_next             = 1'b1;
                snap_next.mode              = mode;
                snap_next.batch_start       = bstart;
                snap_next.top               = top_cylinder;
                snap_next.highest_above     = ha_upd;
                snap_next.any_above         = aa_upd;
                snap_next.highest_below     = hb_upd;
                snap_next.lowest_below      = lb_upd;
                snap_next.any_below         = ab_upd;
                snap_next.running_total     = tot_upd;
                snap_next.overflow          = ovf_upd;
                in_batch_next      = 1'b0;
                head_now_next      = start_head;
                batch_start_next   = '0;
                running_total_next = '0;
                overflow_next      = 1'b0;
                lowest_below_next  = dsdt_pkg::CYL_ONES;
                highest_below_next = '0;
                any_below_next     = 1'b0;
                highest_above_next = '0;
                any_above_next     = 1'b0;
            end
            else
            begin
                in_batch_next      = 1'b1;
                head_now_next      = q_item.cyl;
                batch_start_next   = bstart;
                running_total_next = tot_upd;
                overflow_next      = ovf_upd;
                lowest_below_next  = lb_upd;
                highest_below_next = hb_upd;
                any_below_next     = ab_upd;
                highest_above_next = ha_upd;
                any_above_next     = aa_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_batch_reg      <= 1'b0;
            head_now_reg      <= '0;
            batch_start_reg   <= '0;
            running_total_reg <= '0;
            overflow_reg      <= 1'b0;
            lowest_below_reg  <= dsdt_pkg::CYL_ONES;
            highest_below_reg <= '0;
            any_below_reg     <= 1'b0;
            highest_above_reg <= '0;
            any_above_reg     <= 1'b0;
            snap_valid_reg    <= 1'b0;
        end
        else
        begin
            in_batch_reg      <= in_batch_next;
            head_now_reg      <= head_now_next;
            batch_start_reg   <= batch_start_next;
            running_total_reg <= running_total_next;
            overflow_reg      <= overflow_next;
            lowest_below_reg  <= lowest_below_next;
            highest_below_reg <= highest_below_next;
            any_below_reg     <= any_below_next;
            highest_above_reg <= highest_above_next;
            any_above_reg     <= any_above_next;
            snap_valid_reg    <= snap_valid_next;
        end
    end

    // summary payload
    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

endmodule

`default_nettype wire

FILE: src/dsdt_finish.sv
`default_nettype none

module dsdt_finish (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         snap_valid,
    input  wire dsdt_pkg::snap_t              snap,
    output logic                              fin_ready,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [dsdt_pkg::TOTAL_W-1:0]      out_total,
    output logic                              out_sat
);

    logic                         valid_reg, valid_next;
    logic [dsdt_pkg::TOTAL_W-1:0] total_reg;
    logic                         sat_reg;
    logic [dsdt_pkg::CALC_W-1:0]  up;
    logic [dsdt_pkg::CALC_W-1:0]  sweep;
    logic [dsdt_pkg::TOTAL_W-1:0] total_calc;
    logic                         sat_calc;
    logic                         load;

    assign fin_ready = !valid_reg || out_ready;
    assign load      = snap_valid && fin_ready;
    assign out_valid = valid_reg;
    assign out_total = total_reg;
    assign out_sat   = sat_reg;

    // sweep length for scan and circular scan
    always_comb
    begin
        if (snap.any_above)
        begin
            up = dsdt_pkg::CALC_W'(snap.highest_above - snap.batch_start)
               + dsdt_pkg::CALC_W'(dsdt_pkg::cyl_dist(snap.highest_above, snap.top));
        end
        else
        begin
            up = dsdt_pkg::CALC_W'(dsdt_pkg::cyl_dist(snap.batch_start, snap.top));
        end

        if (snap.mode == dsdt_pkg::MODE_SCAN)
        begin
            sweep = up;
            if (snap.any_below)
            begin
                sweep = up
                      + dsdt_pkg::CALC_W'(dsdt_pkg::cyl_dist(snap.top, snap.highest_below))
                      + dsdt_pkg::CALC_W'(snap.highest_below - snap.lowest_below);
            end
        end
        else
        begin
            sweep = up + dsdt_pkg::CALC_W'(snap.top);
            if (snap.any_below)
            begin
                sweep = sweep + dsdt_pkg::CALC_W'(snap.highest_below);
            end
        end
    end

    // pick the result for the mode
    always_comb
    begin
        unique case (snap.mode)
            dsdt_pkg::MODE_SCAN, dsdt_pkg::MODE_CSCAN:
            begin
                if (sweep > dsdt_pkg::CALC_MAX)
                begin
                    total_calc = dsdt_pkg::TOTAL_MAX;
                    sat_calc   = 1'b1;
                end
                else
                begin
                    total_calc = sweep[dsdt_pkg::TOTAL_W-1:0];
                    sat_calc   = 1'b0;
                end
            end
            default:
            begin
                total_calc = snap.running_total;
                sat_calc   = snap.overflow;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            total_reg <= total_calc;
            sat_reg   <= sat_calc;
        end
    end

endmodule

`default_nettype wire
